// ----- rtl/core/sabf_pkg.sv -----
// Shared types and constants for the slab allocator core.
package sabf_pkg;

    localparam logic [31:0] GUARD_MAGIC     = 32'hDEADBEEF;
    localparam int          MIN_CLASS_BYTES = 32;
    localparam int          MAX_CLASSES     = 8;
    localparam int          CLS_W           = 3;
    localparam int          SIZE_W          = 16;
    localparam int          TOTAL_W         = 17;
    localparam int          MAX_IDX_W       = 17;
    localparam int          CSIZE_W         = 13;
    localparam int          QUEUE_DEPTH     = 2;
    localparam int          QPTR_W          = 1;
    localparam int          QCNT_W          = 2;
    localparam int          CFG_ADDR_W      = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_HEAP_START_ADDR = 2'd0;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // work codes handed from front to back
    localparam logic [1:0] OP_ALLOC_SLAB  = 2'd0;
    localparam logic [1:0] OP_ALLOC_LARGE = 2'd1;
    localparam logic [1:0] OP_PUSH        = 2'd2;
    localparam logic [1:0] OP_REPORT      = 2'd3;

    localparam logic [2:0] ST_REUSED            = 3'd0;
    localparam logic [2:0] ST_NEW_SLAB          = 3'd1;
    localparam logic [2:0] ST_LARGE             = 3'd2;
    localparam logic [2:0] ST_OUT_OF_MEMORY     = 3'd3;
    localparam logic [2:0] ST_FREED             = 3'd4;
    localparam logic [2:0] ST_NULL              = 3'd5;
    localparam logic [2:0] ST_CORRUPT           = 3'd6;
    localparam logic [2:0] ST_LARGE_UNRECLAIMED = 3'd7;

    typedef struct packed {
        logic [1:0]           op;
        logic [2:0]           status;
        logic [CLS_W-1:0]     cls;
        logic [SIZE_W-1:0]    size;
        logic [TOTAL_W-1:0]   aligned;
        logic [MAX_IDX_W-1:0] blk_idx;
    } req_t;

endpackage

// ----- rtl/core/slab_allocator_with_bump_fallback_core.sv -----
// Top level of the slab allocator with bump fallback.
//
// Requests enter on start/busy: a request is taken at a clock edge where start
// is high and busy is low. command selects allocate or free; a free carries
// the pointer, its original size, a null flag and the prefix guard word read
// from memory. The front end classifies each request into a two-entry queue;
// busy is high while that queue is full.
// The back end answers each request with one result, shown for exactly one
// cycle under result_valid: a status, the user pointer and the address where
// the caller must write the suffix guard word. The result is registered
// in the cycle after its request leaves the queue, or after the pop state for
// a reuse, which waits on the registered read of the link memory. Rate is one
// request per cycle, none while a list is popped. The result side has no
// stall; results must be taken as they come. The user writes heap_start over
// the APB port only while no request is pending; the block does not enforce
// this. Reset empties all free lists, zeroes the bump offset and heap_start.
module slab_allocator_with_bump_fallback_core #(
    parameter int HEAP_BYTES   = 65536,
    parameter int SIZE_CLASSES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                command,
    input  logic [sabf_pkg::SIZE_W-1:0]         request_size,
    input  logic [31:0]                         block_pointer,
    input  logic                                pointer_is_null,
    input  logic [31:0]                         prefix_word,
    output logic                                result_valid,
    output logic [2:0]                          status,
    output logic [31:0]                         result_pointer,
    output logic [31:0]                         suffix_guard_address,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sabf_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [31:0]    heap_start_reg;
    logic           cfg_write;
    logic           enq;
    logic           deq;
    logic           q_empty;
    logic           q_full;
    sabf_pkg::req_t enq_data;
    sabf_pkg::req_t q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == sabf_pkg::REG_HEAP_START_ADDR) ? heap_start_reg : 32'd0;
    assign busy      = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_start_reg <= '0;
        end
        else if (cfg_write && paddr == sabf_pkg::REG_HEAP_START_ADDR)
        begin
            heap_start_reg <= pwdata;
        end
    end

    sabf_front #(
        .HEAP_BYTES   (HEAP_BYTES),
        .SIZE_CLASSES (SIZE_CLASSES)
    ) u_front (
        .start           (start),
        .q_full          (q_full),
        .command         (command),
        .request_size    (request_size),
        .block_pointer   (block_pointer),
        .pointer_is_null (pointer_is_null),
        .prefix_word     (prefix_word),
        .heap_start      (heap_start_reg),
        .enq             (enq),
        .entry           (enq_data)
    );

    sabf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (enq),
        .enq_data (enq_data),
        .deq      (deq),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    sabf_back #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .heap_start           (heap_start_reg),
        .q_head               (q_head),
        .q_empty              (q_empty),
        .deq                  (deq),
        .result_valid         (result_valid),
        .status               (status),
        .result_pointer       (result_pointer),
        .suffix_guard_address (suffix_guard_address)
    );

endmodule

// ----- rtl/core/sabf_front.sv -----
// Front end: takes requests and classifies them into work for the back end.
module sabf_front #(
    parameter int HEAP_BYTES   = 65536,
    parameter int SIZE_CLASSES = 8
) (
    input  logic                              start,
    input  logic                              q_full,
    input  logic                              command,
    input  logic [sabf_pkg::SIZE_W-1:0]       request_size,
    input  logic [31:0]                       block_pointer,
    input  logic                              pointer_is_null,
    input  logic [31:0]                       prefix_word,
    input  logic [31:0]                       heap_start,
    output logic                              enq,
    output sabf_pkg::req_t                    entry
);

    localparam int IDX_W = $clog2(HEAP_BYTES / 8);

    logic [sabf_pkg::TOTAL_W-1:0] total;
    logic [sabf_pkg::TOTAL_W-1:0] aligned;
    logic [sabf_pkg::CLS_W-1:0]   cls;
    logic                         fits;
    logic [31:0]                  free_off;
    logic                         off_ok;

    assign enq = start && !q_full;

    assign total    = sabf_pkg::TOTAL_W'(request_size) + sabf_pkg::TOTAL_W'(8);
    assign aligned  = (total + sabf_pkg::TOTAL_W'(7)) & ~sabf_pkg::TOTAL_W'(7);
    assign free_off = block_pointer - 32'd4 - heap_start;
    assign off_ok   = (free_off < 32'(HEAP_BYTES)) && (free_off[2:0] == 3'b000);

    // smallest class that holds the total; scanning down leaves the lowest hit
    always_comb
    begin
        fits = 1'b0;
        cls  = '0;
        for (int c = sabf_pkg::MAX_CLASSES - 1; c >= 0; c--)
        begin
            if (c < SIZE_CLASSES &&
                total <= (sabf_pkg::TOTAL_W'(sabf_pkg::MIN_CLASS_BYTES) << c))
            begin
                fits = 1'b1;
                cls  = sabf_pkg::CLS_W'(c);
            end
        end
    end

    always_comb
    begin
        entry         = '0;
        entry.cls     = cls;
        entry.size    = request_size;
        entry.aligned = aligned;
        entry.blk_idx = sabf_pkg::MAX_IDX_W'(free_off[IDX_W+2:3]);
        if (command == sabf_pkg::CMD_ALLOC)
        begin
            entry.op = fits ? sabf_pkg::OP_ALLOC_SLAB : sabf_pkg::OP_ALLOC_LARGE;
        end
        else if (pointer_is_null)
        begin
            entry.op     = sabf_pkg::OP_REPORT;
            entry.status = sabf_pkg::ST_NULL;
        end
        else if (prefix_word != sabf_pkg::GUARD_MAGIC)
        begin
            entry.op     = sabf_pkg::OP_REPORT;
            entry.status = sabf_pkg::ST_CORRUPT;
        end
        else if (!fits)
        begin
            entry.op     = sabf_pkg::OP_REPORT;
            entry.status = sabf_pkg::ST_LARGE_UNRECLAIMED;
        end
        else if (!off_ok)
        begin
            // pointer outside the heap or misaligned
            entry.op     = sabf_pkg::OP_REPORT;
            entry.status = sabf_pkg::ST_CORRUPT;
        end
        else
        begin
            entry.op = sabf_pkg::OP_PUSH;
        end
    end

endmodule

// ----- rtl/core/sabf_queue.sv -----
// Two-entry queue between the front and back ends.
module sabf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           enq,
    input  sabf_pkg::req_t enq_data,
    input  logic           deq,
    output sabf_pkg::req_t head,
    output logic           empty,
    output logic           full
);

    sabf_pkg::req_t                entries_reg [sabf_pkg::QUEUE_DEPTH];
    logic [sabf_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [sabf_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [sabf_pkg::QCNT_W-1:0]   count_reg;
    logic [sabf_pkg::QCNT_W-1:0]   count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == sabf_pkg::QCNT_W'(sabf_pkg::QUEUE_DEPTH));
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (enq && !deq)
        begin
            count_next = count_reg + sabf_pkg::QCNT_W'(1);
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - sabf_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (enq)
            begin
                wr_ptr_reg <= wr_ptr_reg + sabf_pkg::QPTR_W'(1);
            end
            if (deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + sabf_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entries_reg[wr_ptr_reg] <= enq_data;
        end
    end

endmodule

// ----- rtl/core/sabf_back.sv -----
// Back end: free-list heads, bump pointer, link memory and result register.
module sabf_back #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [31:0]    heap_start,
    input  sabf_pkg::req_t q_head,
    input  logic           q_empty,
    output logic           deq,
    output logic           result_valid,
    output logic [2:0]     status,
    output logic [31:0]    result_pointer,
    output logic [31:0]    suffix_guard_address
);

    localparam int LINK_COUNT = HEAP_BYTES / 8;
    localparam int IDX_W      = $clog2(LINK_COUNT);
    localparam int HEAD_W     = $clog2(LINK_COUNT + 1);
    localparam int OFS_W      = $clog2(HEAP_BYTES + 1);
    localparam int SUM_W      = (OFS_W > sabf_pkg::TOTAL_W ? OFS_W : sabf_pkg::TOTAL_W) + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic                          state_reg, state_next;
    logic [OFS_W-1:0]              bump_reg, bump_next;
    logic [HEAD_W-1:0]             head_reg [sabf_pkg::MAX_CLASSES];
    logic                          head_we;
    logic [sabf_pkg::CLS_W-1:0]    head_wcls;
    logic [HEAD_W-1:0]             head_wdata;

    logic [HEAD_W-1:0]             link_mem [LINK_COUNT];
    logic                          link_we;
    logic [IDX_W-1:0]              link_waddr;
    logic [HEAD_W-1:0]             link_wdata;
    logic [IDX_W-1:0]              link_raddr;
    logic [HEAD_W-1:0]             link_rdata_reg;

    logic [IDX_W-1:0]              cur_idx_reg, cur_idx_next;
    logic [sabf_pkg::CLS_W-1:0]    cur_cls_reg, cur_cls_next;

    logic                          res_valid_reg, res_valid_next;
    logic [2:0]                    res_status_reg, res_status_next;
    logic [31:0]                   res_ptr_reg, res_ptr_next;
    logic [31:0]                   res_sfx_reg, res_sfx_next;

    logic [HEAD_W-1:0]             head_sel;
    logic [IDX_W-1:0]              pop_idx;
    logic [sabf_pkg::CLS_W-1:0]    cls_sel;
    logic [sabf_pkg::CSIZE_W-1:0]  csize;
    logic [31:0]                   base_off;
    logic [31:0]                   base;
    logic [31:0]                   slab_ptr;
    logic [31:0]                   slab_sfx;
    logic [31:0]                   large_sfx;
    logic                          slab_oom;
    logic                          large_oom;

    assign head_sel   = head_reg[q_head.cls];
    assign pop_idx    = IDX_W'(head_sel - HEAD_W'(1));
    assign link_raddr = pop_idx;
    assign cls_sel    = (state_reg == S_POP) ? cur_cls_reg : q_head.cls;
    assign csize      = sabf_pkg::CSIZE_W'(sabf_pkg::MIN_CLASS_BYTES) << cls_sel;
    assign base_off   = (state_reg == S_POP) ? 32'({cur_idx_reg, 3'b000}) : 32'(bump_reg);
    assign base       = heap_start + base_off;
    assign slab_ptr   = base + 32'd4;
    assign slab_sfx   = base + 32'(csize) - 32'd4;
    assign large_sfx  = slab_ptr + 32'(q_head.size);
    assign slab_oom   = (SUM_W'(bump_reg) + SUM_W'(csize)) > SUM_W'(HEAP_BYTES);
    assign large_oom  = (SUM_W'(bump_reg) + SUM_W'(q_head.aligned)) > SUM_W'(HEAP_BYTES);

    always_comb
    begin
        deq             = 1'b0;
        state_next      = state_reg;
        bump_next       = bump_reg;
        head_we         = 1'b0;
        head_wcls       = q_head.cls;
        head_wdata      = HEAD_W'(q_head.blk_idx[IDX_W-1:0]) + HEAD_W'(1);
        link_we         = 1'b0;
        link_waddr      = q_head.blk_idx[IDX_W-1:0];
        link_wdata      = head_sel;
        cur_idx_next    = cur_idx_reg;
        cur_cls_next    = cur_cls_reg;
        res_valid_next  = 1'b0;
        res_status_next = res_status_reg;
        res_ptr_next    = 32'd0;
        res_sfx_next    = 32'd0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    deq = 1'b1;
                    unique case (q_head.op)
                        sabf_pkg::OP_ALLOC_SLAB:
                        begin
                            if (head_sel != '0)
                            begin
                                // link read issued now, head updated next cycle
                                state_next   = S_POP;
                                cur_idx_next = pop_idx;
                                cur_cls_next = q_head.cls;
                            end
                            else if (slab_oom)
                            begin
                                res_valid_next  = 1'b1;
                                res_status_next = sabf_pkg::ST_OUT_OF_MEMORY;
                            end
                            else
                            begin
                                res_valid_next  = 1'b1;
                                res_status_next = sabf_pkg::ST_NEW_SLAB;
                                res_ptr_next    = slab_ptr;
                                res_sfx_next    = slab_sfx;
                                bump_next       = bump_reg + OFS_W'(csize);
                            end
                        end
                        sabf_pkg::OP_ALLOC_LARGE:
                        begin
                            res_valid_next = 1'b1;
                            if (large_oom)
                            begin
                                res_status_next = sabf_pkg::ST_OUT_OF_MEMORY;
                            end
                            else
                            begin
                                res_status_next = sabf_pkg::ST_LARGE;
                                res_ptr_next    = slab_ptr;
                                res_sfx_next    = large_sfx;
                                bump_next       = bump_reg + OFS_W'(q_head.aligned);
                            end
                        end
                        sabf_pkg::OP_PUSH:
                        begin
                            link_we         = 1'b1;
                            head_we         = 1'b1;
                            res_valid_next  = 1'b1;
                            res_status_next = sabf_pkg::ST_FREED;
                        end
                        sabf_pkg::OP_REPORT:
                        begin
                            res_valid_next  = 1'b1;
                            res_status_next = q_head.status;
                        end
                        default:
                        begin
                            res_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                head_we         = 1'b1;
                head_wcls       = cur_cls_reg;
                head_wdata      = link_rdata_reg;
                res_valid_next  = 1'b1;
                res_status_next = sabf_pkg::ST_REUSED;
                res_ptr_next    = slab_ptr;
                res_sfx_next    = slab_sfx;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bump_reg      <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < sabf_pkg::MAX_CLASSES; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            bump_reg      <= bump_next;
            res_valid_reg <= res_valid_next;
            if (head_we)
            begin
                head_reg[head_wcls] <= head_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_idx_reg    <= cur_idx_next;
        cur_cls_reg    <= cur_cls_next;
        res_status_reg <= res_status_next;
        res_ptr_reg    <= res_ptr_next;
        res_sfx_reg    <= res_sfx_next;
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata_reg <= link_mem[link_raddr];
    end

    assign result_valid         = res_valid_reg;
    assign status               = res_status_reg;
    assign result_pointer       = res_ptr_reg;
    assign suffix_guard_address = res_sfx_reg;

    a_pop_reports_reuse: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |=> res_valid_reg && res_status_reg == sabf_pkg::ST_REUSED)
        else $error("free-list pop did not report a reused block");

    a_bump_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg <= OFS_W'(HEAP_BYTES))
        else $error("bump offset past end of heap");

    a_fail_zero_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_status_reg != sabf_pkg::ST_REUSED &&
        res_status_reg != sabf_pkg::ST_NEW_SLAB && res_status_reg != sabf_pkg::ST_LARGE
        |-> res_ptr_reg == 32'd0 && res_sfx_reg == 32'd0)
        else $error("nonzero pointer on a result without an allocation");

    a_free_keeps_bump: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_status_reg == sabf_pkg::ST_FREED |-> $stable(bump_reg))
        else $error("free request moved the bump offset");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the slab allocator core with bump fallback.
module tb;

    localparam int unsigned HEAP_BYTES     = 65536;
    localparam int unsigned SIZE_CLASSES   = 8;
    localparam int unsigned LINK_COUNT     = HEAP_BYTES / 8;
    localparam int          DRAIN_CYCLES   = 4;
    localparam int          WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] pointer;
        logic [31:0] suffix;
    } alloc_result_t;

    typedef struct packed {
        logic [31:0] pointer;
        logic [15:0] size;
    } live_block_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic                            command = sabf_pkg::CMD_ALLOC;
    logic [sabf_pkg::SIZE_W-1:0]     request_size = '0;
    logic [31:0]                     block_pointer = '0;
    logic                            pointer_is_null = 1'b0;
    logic [31:0]                     prefix_word = '0;
    logic                            result_valid;
    logic [2:0]                      status;
    logic [31:0]                     result_pointer;
    logic [31:0]                     suffix_guard_address;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [sabf_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    // allocator state as the testbench sees it
    logic [31:0]           heap_origin = '0;
    int unsigned           bump_used = 0;
    int unsigned           list_head [SIZE_CLASSES];
    int unsigned           link_mem [LINK_COUNT];

    alloc_result_t         pending_results [$];
    live_block_t           live_blocks [$];
    alloc_result_t         oldest_expected;
    int                    failures = 0;
    int                    gap_max = 19;
    int                    idle_cycles = 0;

    slab_allocator_with_bump_fallback_core #(
        .HEAP_BYTES   (HEAP_BYTES),
        .SIZE_CLASSES (SIZE_CLASSES)
    ) DUT (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .command              (command),
        .request_size         (request_size),
        .block_pointer        (block_pointer),
        .pointer_is_null      (pointer_is_null),
        .prefix_word          (prefix_word),
        .result_valid         (result_valid),
        .status               (status),
        .result_pointer       (result_pointer),
        .suffix_guard_address (suffix_guard_address),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic alloc_result_t predict_allocator(input logic cmd,
                                                        input logic [15:0] size,
                                                        input logic [31:0] ptr,
                                                        input logic nul,
                                                        input logic [31:0] prefix);
        alloc_result_t r;
        logic [16:0]   total;
        logic [31:0]   off;
        int unsigned   cls;
        int unsigned   csize;
        int unsigned   idx;
        int unsigned   aligned;
        r = '{sabf_pkg::ST_OUT_OF_MEMORY, 32'd0, 32'd0};
        total = {1'b0, size} + 17'd8;
        cls = SIZE_CLASSES;
        for (int c = SIZE_CLASSES - 1; c >= 0; c--)
            if (total <= (sabf_pkg::MIN_CLASS_BYTES << c))
                cls = c;
        if (cmd == sabf_pkg::CMD_ALLOC)
        begin
            if (cls < SIZE_CLASSES)
            begin
                csize = sabf_pkg::MIN_CLASS_BYTES << cls;
                if (list_head[cls] != 0)
                begin
                    idx = list_head[cls] - 1;
                    list_head[cls] = link_mem[idx];
                    r.status  = sabf_pkg::ST_REUSED;
                    r.pointer = heap_origin + idx * 8 + 4;
                    r.suffix  = heap_origin + idx * 8 + csize - 4;
                end
                else if (bump_used + csize <= HEAP_BYTES)
                begin
                    r.status  = sabf_pkg::ST_NEW_SLAB;
                    r.pointer = heap_origin + bump_used + 4;
                    r.suffix  = heap_origin + bump_used + csize - 4;
                    bump_used += csize;
                end
            end
            else
            begin
                aligned = (int'(total) + 7) & ~32'd7;
                if (bump_used + aligned <= HEAP_BYTES)
                begin
                    r.status  = sabf_pkg::ST_LARGE;
                    r.pointer = heap_origin + bump_used + 4;
                    r.suffix  = r.pointer + size;
                    bump_used += aligned;
                end
            end
        end
        else if (nul)
            r.status = sabf_pkg::ST_NULL;
        else if (prefix != sabf_pkg::GUARD_MAGIC)
            r.status = sabf_pkg::ST_CORRUPT;
        else if (cls >= SIZE_CLASSES)
            r.status = sabf_pkg::ST_LARGE_UNRECLAIMED;
        else
        begin
            off = ptr - 32'd4 - heap_origin;
            // outside the heap or off the 8-byte grid counts as corrupt
            if (off >= HEAP_BYTES || off[2:0] != 3'd0)
                r.status = sabf_pkg::ST_CORRUPT;
            else
            begin
                idx = off >> 3;
                link_mem[idx] = list_head[cls];
                list_head[cls] = idx + 1;
                r.status = sabf_pkg::ST_FREED;
            end
        end
        return r;
    endfunction

    task automatic send_request(input logic cmd, input logic [15:0] size,
                                input logic [31:0] ptr, input logic nul,
                                input logic [31:0] prefix, output alloc_result_t predicted);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        command         <= cmd;
        request_size    <= size;
        block_pointer   <= ptr;
        pointer_is_null <= nul;
        prefix_word     <= prefix;
        do
            @(posedge clk);
        while (busy);
        predicted = predict_allocator(cmd, size, ptr, nul, prefix);
        pending_results.push_back(predicted);
        if (cmd == sabf_pkg::CMD_ALLOC && predicted.status != sabf_pkg::ST_OUT_OF_MEMORY)
            live_blocks.push_back('{predicted.pointer, size});
    endtask

    task automatic drain_requests();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [sabf_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [sabf_pkg::CFG_ADDR_W-1:0] addr,
                            output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // live pointers move with the heap so later frees stay well formed
    task automatic set_heap_start(input logic [31:0] value);
        logic [31:0] readback;
        live_block_t blk;
        drain_requests();
        apb_write(sabf_pkg::REG_HEAP_START_ADDR, value);
        for (int i = 0; i < live_blocks.size(); i++)
        begin
            blk = live_blocks[i];
            blk.pointer = blk.pointer - heap_origin + value;
            live_blocks[i] = blk;
        end
        heap_origin = value;
        apb_read(sabf_pkg::REG_HEAP_START_ADDR, readback);
        if (readback !== heap_origin)
        begin
            $error("heap_start: expected %h, actual %h", heap_origin, readback);
            failures++;
        end
    endtask

    task automatic test_register_access();
        logic [31:0] readback;
        apb_read(sabf_pkg::REG_HEAP_START_ADDR, readback);
        if (readback !== 32'd0)
        begin
            $error("heap_start: expected %h, actual %h", 32'd0, readback);
            failures++;
        end
        set_heap_start(32'hFFFF_FFFF);
        set_heap_start(32'h0000_0000);
        set_heap_start(32'h0000_1000);
    endtask

    task automatic test_directed_requests();
        alloc_result_t got;
        alloc_result_t first;
        alloc_result_t big;
        gap_max = 3;
        send_request(sabf_pkg::CMD_ALLOC, 16'd0, '0, 1'b0, '0, first);
        send_request(sabf_pkg::CMD_ALLOC, 16'd24, '0, 1'b0, '0, got);
        send_request(sabf_pkg::CMD_ALLOC, 16'd25, '0, 1'b0, '0, got);
        // top size of each class
        for (int c = 1; c < SIZE_CLASSES; c++)
            send_request(sabf_pkg::CMD_ALLOC, 16'((sabf_pkg::MIN_CLASS_BYTES << c) - 8),
                         '0, 1'b0, '0, got);
        send_request(sabf_pkg::CMD_ALLOC, 16'd4089, '0, 1'b0, '0, big);
        send_request(sabf_pkg::CMD_ALLOC, 16'hFFFF, '0, 1'b0, '0, got);
        // null free wins even with a bad guard
        send_request(sabf_pkg::CMD_FREE, 16'd0, 32'hFFFF_FFFF, 1'b1,
                     ~sabf_pkg::GUARD_MAGIC, got);
        send_request(sabf_pkg::CMD_FREE, 16'd0, first.pointer, 1'b0,
                     ~sabf_pkg::GUARD_MAGIC, got);
        send_request(sabf_pkg::CMD_FREE, 16'd4089, big.pointer, 1'b0,
                     sabf_pkg::GUARD_MAGIC, got);
        send_request(sabf_pkg::CMD_FREE, 16'd0, first.pointer + 32'd2, 1'b0,
                     sabf_pkg::GUARD_MAGIC, got);
        send_request(sabf_pkg::CMD_FREE, 16'd0, heap_origin, 1'b0,
                     sabf_pkg::GUARD_MAGIC, got);
        // double free, then both copies come back
        send_request(sabf_pkg::CMD_FREE, 16'd0, first.pointer, 1'b0,
                     sabf_pkg::GUARD_MAGIC, got);
        send_request(sabf_pkg::CMD_FREE, 16'd24, first.pointer, 1'b0,
                     sabf_pkg::GUARD_MAGIC, got);
        send_request(sabf_pkg::CMD_ALLOC, 16'd0, '0, 1'b0, '0, got);
        send_request(sabf_pkg::CMD_ALLOC, 16'd24, '0, 1'b0, '0, got);
        // last link entry of the heap
        send_request(sabf_pkg::CMD_FREE, 16'd0, heap_origin + HEAP_BYTES - 4, 1'b0,
                     sabf_pkg::GUARD_MAGIC, got);
        send_request(sabf_pkg::CMD_ALLOC, 16'd8, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, got);
        drain_requests();
    endtask

    task automatic run_random_traffic(input int count);
        alloc_result_t got;
        live_block_t   blk;
        logic          cmd;
        logic [15:0]   size;
        logic [31:0]   ptr;
        int            roll;
        int            pick;
        int            cls;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                roll = $urandom_range(0, 2);
                gap_max = (roll == 0) ? 0 : (roll == 1) ? 4 : 19;
            end
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                cmd = ($urandom_range(0, 7) == 0) ? sabf_pkg::CMD_ALLOC : sabf_pkg::CMD_FREE;
                size = (cmd == sabf_pkg::CMD_ALLOC) ? 16'($urandom_range(0, 4088))
                                                    : 16'($urandom);
                if ($urandom_range(0, 1) == 0)
                    ptr = $urandom;
                else
                    ptr = heap_origin + ($urandom_range(0, LINK_COUNT - 1) << 3) + 4;
                send_request(cmd, size, ptr, $urandom_range(0, 3) == 0,
                             ($urandom_range(0, 1) == 0) ? sabf_pkg::GUARD_MAGIC
                                                         : 32'($urandom), got);
            end
            else if (live_blocks.size() != 0 && (roll < 48 || live_blocks.size() > 48))
            begin
                pick = $urandom_range(0, live_blocks.size() - 1);
                blk = live_blocks[pick];
                // now and then the block stays listed and gets freed twice
                if ($urandom_range(0, 19) != 0)
                    live_blocks.delete(pick);
                send_request(sabf_pkg::CMD_FREE, blk.size, blk.pointer, 1'b0,
                             sabf_pkg::GUARD_MAGIC, got);
            end
            else
            begin
                if ($urandom_range(0, 99) < 2)
                begin
                    if ($urandom_range(0, 9) == 0)
                        size = 16'($urandom_range(4089, 65535));
                    else
                        size = 16'($urandom_range(4089, 4600));
                end
                else
                begin
                    cls = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                       : $urandom_range(4, 7);
                    if (cls == 0)
                        size = 16'($urandom_range(0, sabf_pkg::MIN_CLASS_BYTES - 8));
                    else
                        size = 16'($urandom_range(
                                   (sabf_pkg::MIN_CLASS_BYTES << (cls - 1)) - 7,
                                   (sabf_pkg::MIN_CLASS_BYTES << cls) - 8));
                end
                send_request(sabf_pkg::CMD_ALLOC, size, $urandom,
                             1'($urandom_range(0, 1)), $urandom, got);
            end
        end
        drain_requests();
    endtask

    task automatic test_random_traffic();
        logic [31:0] bases [5];
        bases[0] = 32'h0000_0000;
        bases[1] = 32'hFFFF_FFFF;
        bases[2] = $urandom;
        bases[3] = 32'h8000_0000;
        bases[4] = $urandom & ~32'h7;
        for (int p = 0; p < 5; p++)
        begin
            set_heap_start(bases[p]);
            run_random_traffic(170);
        end
    endtask

    // fill the bump region, then drain class lists until slabs run out too
    task automatic test_heap_exhaustion();
        alloc_result_t got;
        live_block_t   blk;
        int            tries;
        gap_max = 2;
        tries = 0;
        do
        begin
            send_request(sabf_pkg::CMD_ALLOC, 16'd8000, '0, 1'b0, '0, got);
            tries++;
        end
        while (got.status != sabf_pkg::ST_OUT_OF_MEMORY && tries < 20);
        tries = 0;
        do
        begin
            send_request(sabf_pkg::CMD_ALLOC, 16'd4088, '0, 1'b0, '0, got);
            tries++;
        end
        while (got.status != sabf_pkg::ST_OUT_OF_MEMORY && tries < 100);
        tries = 0;
        do
        begin
            send_request(sabf_pkg::CMD_ALLOC, 16'd0, '0, 1'b0, '0, got);
            tries++;
        end
        while (got.status != sabf_pkg::ST_OUT_OF_MEMORY && tries < 400);
        blk = live_blocks.pop_back();
        send_request(sabf_pkg::CMD_FREE, blk.size, blk.pointer, 1'b0,
                     sabf_pkg::GUARD_MAGIC, got);
        send_request(sabf_pkg::CMD_ALLOC, blk.size, '0, 1'b0, '0, got);
        drain_requests();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending: status %0d", status);
                failures++;
            end
            else
            begin
                oldest_expected = pending_results.pop_front();
                if (status !== oldest_expected.status)
                begin
                    $error("status: expected %0d, actual %0d", oldest_expected.status, status);
                    failures++;
                end
                if (result_pointer !== oldest_expected.pointer)
                begin
                    $error("result_pointer: expected %h, actual %h",
                           oldest_expected.pointer, result_pointer);
                    failures++;
                end
                if (suffix_guard_address !== oldest_expected.suffix)
                begin
                    $error("suffix_guard_address: expected %h, actual %h",
                           oldest_expected.suffix, suffix_guard_address);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("slab_allocator_with_bump_fallback_core regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_register_access();
        test_directed_requests();
        test_random_traffic();
        test_heap_exhaustion();
        if (failures == 0)
            $display("slab_allocator_with_bump_fallback_core regression: pass");
        else
            $display("slab_allocator_with_bump_fallback_core regression: fail");
        $finish;
    end

endmodule
